[rtl/ims_pkg.sv]
// Shared types, constants and helpers for the Ising Metropolis site update core.
package ims_pkg;

    // Lattice geometry.
    localparam int SIDE   = 64;
    localparam int NSITES = SIDE * SIDE;
    localparam int ADDR_W = (SIDE > 1) ? $clog2(SIDE) : 1;

    // Payload widths fixed by the interface.
    localparam int POS_W  = 6;
    localparam int FRAC_W = 32;
    localparam int MAG_W  = 14;
    localparam int CFG_W  = 32;
    localparam int THR_N  = 10;

    // APB register file geometry: 64-bit registers at 8-byte strides.
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int REG_LSB = 3;

    // Energy word: |J*4| needs 34 bits plus the field term, signed.
    localparam int E_W = 37;

    localparam logic [MAG_W-1:0] MAG_RST = MAG_W'(NSITES);
    localparam logic [CFG_W-1:0] COUPLING_RST = 32'h0001_0000;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIDE-1:0]   t_row_word;

    typedef enum logic [APB_AW-REG_LSB-1:0] {
        REG_COUPLING   = 3'd0,
        REG_FIELD_TERM = 3'd1,
        REG_THR_01     = 3'd2,
        REG_THR_23     = 3'd3,
        REG_THR_45     = 3'd4,
        REG_THR_67     = 3'd5,
        REG_THR_89     = 3'd6
    } t_reg_idx;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_UPDATE = 1'b1
    } t_cmd;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic signed [CFG_W-1:0]       coupling;
        logic signed [CFG_W-1:0]       field_term;
        logic [THR_N-1:0][FRAC_W-1:0]  thr;
    } t_cfg;

    // The three lattice rows that surround one site.
    typedef struct packed {
        t_row_word up;
        t_row_word mid;
        t_row_word dn;
    } t_rows;

    // Decision for one site.
    typedef struct packed {
        logic old_spin;
        logic new_spin;
        logic flip;
    } t_eval;

    // Lattice write request.
    typedef struct packed {
        logic  en;
        t_addr row;
        t_addr col;
        logic  spin;
    } t_wr;

    function automatic t_addr wrap_dec(t_addr a);
        t_addr r;
        if (a == '0) begin
            r = t_addr'(SIDE - 1);
        end else begin
            r = a - t_addr'(1);
        end
        return r;
    endfunction

    function automatic t_addr wrap_inc(t_addr a);
        t_addr r;
        if (a == t_addr'(SIDE - 1)) begin
            r = '0;
        end else begin
            r = a + t_addr'(1);
        end
        return r;
    endfunction

endpackage

[rtl/ims_cfg_regs.sv]
// APB register file holding the coupling, field term and acceptance thresholds.
module ims_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ims_pkg::APB_AW-1:0]        paddr,
    input  logic [ims_pkg::APB_DW-1:0]        pwdata,
    output logic [ims_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    output ims_pkg::t_cfg                     o_cfg
);

    logic [ims_pkg::CFG_W-1:0]  r_coupling;
    logic [ims_pkg::CFG_W-1:0]  r_field_term;
    logic [ims_pkg::APB_DW-1:0] r_thr_01;
    logic [ims_pkg::APB_DW-1:0] r_thr_23;
    logic [ims_pkg::APB_DW-1:0] r_thr_45;
    logic [ims_pkg::APB_DW-1:0] r_thr_67;
    logic [ims_pkg::APB_DW-1:0] r_thr_89;

    logic              wr_en;
    ims_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = ims_pkg::t_reg_idx'(paddr[ims_pkg::APB_AW-1:ims_pkg::REG_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling   <= ims_pkg::COUPLING_RST;
            r_field_term <= '0;
            r_thr_01     <= '0;
            r_thr_23     <= '0;
            r_thr_45     <= '0;
            r_thr_67     <= '0;
            r_thr_89     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                ims_pkg::REG_COUPLING:   r_coupling   <= pwdata[ims_pkg::CFG_W-1:0];
                ims_pkg::REG_FIELD_TERM: r_field_term <= pwdata[ims_pkg::CFG_W-1:0];
                ims_pkg::REG_THR_01:     r_thr_01     <= pwdata;
                ims_pkg::REG_THR_23:     r_thr_23     <= pwdata;
                ims_pkg::REG_THR_45:     r_thr_45     <= pwdata;
                ims_pkg::REG_THR_67:     r_thr_67     <= pwdata;
                ims_pkg::REG_THR_89:     r_thr_89     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ims_pkg::REG_COUPLING:   prdata = {32'b0, r_coupling};
            ims_pkg::REG_FIELD_TERM: prdata = {32'b0, r_field_term};
            ims_pkg::REG_THR_01:     prdata = r_thr_01;
            ims_pkg::REG_THR_23:     prdata = r_thr_23;
            ims_pkg::REG_THR_45:     prdata = r_thr_45;
            ims_pkg::REG_THR_67:     prdata = r_thr_67;
            ims_pkg::REG_THR_89:     prdata = r_thr_89;
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.coupling   = r_coupling;
    assign o_cfg.field_term = r_field_term;
    assign o_cfg.thr        = {r_thr_89, r_thr_67, r_thr_45, r_thr_23, r_thr_01};

endmodule

[rtl/ims_lattice_mem.sv]
// Lattice storage: three row-wide copies, clear sweep after reset, write forwarding.
module ims_lattice_mem (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  ims_pkg::t_addr i_rd_row,
    input  ims_pkg::t_wr   i_wr,
    output logic           o_clr_busy,
    output ims_pkg::t_rows o_rows
);

    ims_pkg::t_row_word mem_up  [ims_pkg::SIDE];
    ims_pkg::t_row_word mem_mid [ims_pkg::SIDE];
    ims_pkg::t_row_word mem_dn  [ims_pkg::SIDE];

    logic           r_clr_busy;
    ims_pkg::t_addr r_clr_row;

    ims_pkg::t_addr     up_row;
    ims_pkg::t_addr     dn_row;
    ims_pkg::t_addr     r_up_row;
    ims_pkg::t_addr     r_mid_row;
    ims_pkg::t_addr     r_dn_row;
    ims_pkg::t_row_word r_up_word;
    ims_pkg::t_row_word r_mid_word;
    ims_pkg::t_row_word r_dn_word;

    // Most recent write, patched into read data that may have missed it.
    logic           r_fwd_vld;
    ims_pkg::t_addr r_fwd_row;
    ims_pkg::t_addr r_fwd_col;
    logic           r_fwd_spin;

    assign up_row     = ims_pkg::wrap_dec(i_rd_row);
    assign dn_row     = ims_pkg::wrap_inc(i_rd_row);
    assign o_clr_busy = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_row == ims_pkg::t_addr'(ims_pkg::SIDE - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_row <= r_clr_row + ims_pkg::t_addr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_up[r_clr_row]  <= '0;
            mem_mid[r_clr_row] <= '0;
            mem_dn[r_clr_row]  <= '0;
        end else if (i_wr.en) begin
            mem_up[i_wr.row][i_wr.col]  <= i_wr.spin;
            mem_mid[i_wr.row][i_wr.col] <= i_wr.spin;
            mem_dn[i_wr.row][i_wr.col]  <= i_wr.spin;
        end
        if (i_rd_en) begin
            r_up_word  <= mem_up[up_row];
            r_mid_word <= mem_mid[i_rd_row];
            r_dn_word  <= mem_dn[dn_row];
            r_up_row   <= up_row;
            r_mid_row  <= i_rd_row;
            r_dn_row   <= dn_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_fwd_vld <= 1'b1;
        end
        if (i_wr.en) begin
            r_fwd_row  <= i_wr.row;
            r_fwd_col  <= i_wr.col;
            r_fwd_spin <= i_wr.spin;
        end
    end

    always_comb begin
        o_rows.up  = r_up_word;
        o_rows.mid = r_mid_word;
        o_rows.dn  = r_dn_word;
        if (r_fwd_vld && r_fwd_row == r_up_row) begin
            o_rows.up[r_fwd_col] = r_fwd_spin;
        end
        if (r_fwd_vld && r_fwd_row == r_mid_row) begin
            o_rows.mid[r_fwd_col] = r_fwd_spin;
        end
        if (r_fwd_vld && r_fwd_row == r_dn_row) begin
            o_rows.dn[r_fwd_col] = r_fwd_spin;
        end
    end

endmodule

[rtl/ims_site_eval.sv]
// Neighbor sum, energy sign and Metropolis acceptance for one site.
module ims_site_eval (
    input  ims_pkg::t_rows               i_rows,
    input  ims_pkg::t_addr               i_col,
    input  logic                         i_cmd,
    input  logic                         i_spin_in,
    input  logic [ims_pkg::FRAC_W-1:0]   i_rand_frac,
    input  ims_pkg::t_cfg                i_cfg,
    output ims_pkg::t_eval               o_eval
);

    ims_pkg::t_addr                 lf_col;
    ims_pkg::t_addr                 rt_col;
    logic                           old_spin;
    logic [3:0]                     nbr;
    logic [2:0]                     plus_cnt;
    logic signed [4:0]              n_sum;
    logic signed [ims_pkg::E_W-1:0] energy;
    logic                           se_nonneg;
    logic [3:0]                     thr_idx;
    logic                           accept;

    assign lf_col   = ims_pkg::wrap_dec(i_col);
    assign rt_col   = ims_pkg::wrap_inc(i_col);
    assign old_spin = i_rows.mid[i_col];
    assign nbr      = {i_rows.up[i_col], i_rows.dn[i_col],
                       i_rows.mid[lf_col], i_rows.mid[rt_col]};

    // A clear bit is a +1 neighbor; n = 2*plus_cnt - 4.
    assign plus_cnt = 3'd4 - 3'($countones(nbr));
    assign n_sum    = $signed({1'b0, plus_cnt, 1'b0}) - 5'sd4;
    assign energy   = ims_pkg::E_W'($signed(i_cfg.coupling)) * ims_pkg::E_W'(n_sum)
                    + ims_pkg::E_W'($signed(i_cfg.field_term));

    // s*E >= 0: for s=+1 E is non-negative, for s=-1 E is non-positive.
    assign se_nonneg = old_spin ? (energy[ims_pkg::E_W-1] || energy == '0)
                                : !energy[ims_pkg::E_W-1];
    assign thr_idx   = old_spin ? 4'd5 + 4'(plus_cnt) : 4'(plus_cnt);
    assign accept    = se_nonneg || (i_rand_frac < i_cfg.thr[thr_idx]);

    always_comb begin
        o_eval.old_spin = old_spin;
        if (i_cmd == ims_pkg::CMD_WRITE) begin
            o_eval.new_spin = i_spin_in;
            o_eval.flip     = 1'b0;
        end else begin
            o_eval.new_spin = old_spin ^ accept;
            o_eval.flip     = accept;
        end
    end

endmodule

[rtl/ising_metropolis_site_update_core.sv]
// Top level of the Ising Metropolis site update core.
// This core keeps a 64 x 64 lattice of +1/-1 spins with wrapped edges and the
// running magnetization, and it runs one write or Metropolis update per item.
// It takes one item per clock cycle while the output is not stalled: the item
// is registered together with the three lattice rows around its site at the
// input transfer, and its result is registered as the item leaves stage one,
// which it does once the result register is free or drains; the lattice is
// written at that same edge. The lattice sits in three row-wide copies so that
// the rows above, at and below the site are all read in the transfer cycle; a
// write that lands in the same cycle is forwarded into the fresh read data.
// After reset the core clears the lattice to all +1, one row a cycle, and
// keeps o_ready low during that sweep; the APB port is usable throughout.
module ising_metropolis_site_update_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ims_pkg::APB_AW-1:0]        paddr,
    input  logic [ims_pkg::APB_DW-1:0]        pwdata,
    output logic [ims_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,

    // Item input channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_cmd,
    input  logic [ims_pkg::POS_W-1:0]         i_row,
    input  logic [ims_pkg::POS_W-1:0]         i_col,
    input  logic                              i_spin_in,
    input  logic [ims_pkg::FRAC_W-1:0]        i_rand_frac,

    // Result output channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_spin_out,
    output logic                              o_flipped,
    output logic signed [ims_pkg::MAG_W-1:0]  o_magnet_sum
);

    ims_pkg::t_cfg  cfg;
    ims_pkg::t_rows rows;
    ims_pkg::t_eval eval;
    ims_pkg::t_wr   wr;
    logic           clr_busy;

    // Input stage: the accepted item, waiting for its rows to come back.
    logic                         r_s1_vld;
    logic                         r_s1_cmd;
    ims_pkg::t_addr               r_s1_row;
    ims_pkg::t_addr               r_s1_col;
    logic                         r_s1_inr;
    logic                         r_s1_spin;
    logic [ims_pkg::FRAC_W-1:0]   r_s1_rand;

    // Result stage and running magnetization.
    logic                         r_out_vld;
    logic                         r_out_spin;
    logic                         r_out_flip;
    logic [ims_pkg::MAG_W-1:0]    r_out_mag;
    logic [ims_pkg::MAG_W-1:0]    r_mag;
    logic [ims_pkg::MAG_W-1:0]    n_mag;

    logic in_xfer;
    logic s1_adv;
    logic in_range;
    logic changed;

    // The stage-one item moves on when the result register is free or drains now.
    assign s1_adv  = r_s1_vld && (!r_out_vld || i_ready);
    assign o_ready = !clr_busy && (!r_s1_vld || s1_adv);
    assign in_xfer = i_valid && o_ready;

    // Sites beyond the lattice leave everything untouched.
    assign in_range = (32'(i_row) < ims_pkg::SIDE) && (32'(i_col) < ims_pkg::SIDE);

    ims_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ims_lattice_mem u_lattice_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_xfer),
        .i_rd_row   (ims_pkg::t_addr'(i_row)),
        .i_wr       (wr),
        .o_clr_busy (clr_busy),
        .o_rows     (rows)
    );

    ims_site_eval u_site_eval (
        .i_rows      (rows),
        .i_col       (r_s1_col),
        .i_cmd       (r_s1_cmd),
        .i_spin_in   (r_s1_spin),
        .i_rand_frac (r_s1_rand),
        .i_cfg       (cfg),
        .o_eval      (eval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
        if (in_xfer) begin
            r_s1_cmd  <= i_cmd;
            r_s1_row  <= ims_pkg::t_addr'(i_row);
            r_s1_col  <= ims_pkg::t_addr'(i_col);
            r_s1_inr  <= in_range;
            r_s1_spin <= i_spin_in;
            r_s1_rand <= i_rand_frac;
        end
    end

    // Lattice write-back happens as the item leaves stage one.
    assign changed = r_s1_inr && (eval.new_spin != eval.old_spin);
    assign wr.en   = s1_adv && changed;
    assign wr.row  = r_s1_row;
    assign wr.col  = r_s1_col;
    assign wr.spin = eval.new_spin;

    // A spin going to -1 lowers the sum by two, going to +1 raises it by two.
    always_comb begin
        n_mag = r_mag;
        if (changed) begin
            n_mag = eval.new_spin ? r_mag - ims_pkg::MAG_W'(2)
                                  : r_mag + ims_pkg::MAG_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_mag     <= ims_pkg::MAG_RST;
        end else begin
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_mag     <= n_mag;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (s1_adv) begin
            r_out_spin <= r_s1_inr && eval.new_spin;
            r_out_flip <= r_s1_inr && eval.flip;
            r_out_mag  <= n_mag;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_spin_out   = r_out_spin;
    assign o_flipped    = r_out_flip;
    assign o_magnet_sum = r_out_mag;

endmodule
